>>> rtl/akd_pkg.sv
package akd_pkg;

  localparam int NUM_BUTTONS = 5;
  localparam int NUM_FLAGS   = 5;
  localparam int SAMPLE_W    = 8;
  localparam int BTN_IDX_W   = 3;
  localparam int COUNT_W     = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 32;
  localparam int OUT_USED_W  = NUM_BUTTONS * NUM_FLAGS;

  // flag bit positions
  localparam int FLAG_PRESSED   = 0;
  localparam int FLAG_UNPRESSED = 1;
  localparam int FLAG_PRESS_EV  = 2;
  localparam int FLAG_REL_EV    = 3;
  localparam int FLAG_LOCKED    = 4;

  localparam logic [NUM_FLAGS-1:0] FLAGS_RESET = NUM_FLAGS'(1) << FLAG_UNPRESSED;

  localparam logic [SAMPLE_W-1:0] RIGHT_UPPER_RST  = 8'd25;
  localparam logic [SAMPLE_W-1:0] UP_UPPER_RST     = 8'd65;
  localparam logic [SAMPLE_W-1:0] DOWN_UPPER_RST   = 8'd115;
  localparam logic [SAMPLE_W-1:0] LEFT_UPPER_RST   = 8'd180;
  localparam logic [SAMPLE_W-1:0] SELECT_UPPER_RST = 8'd230;
  localparam logic [COUNT_W-1:0]  LIMIT_RST        = 4'd5;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2
  } act_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RIGHT_UPPER  = 3'd0,
    REG_UP_UPPER     = 3'd1,
    REG_DOWN_UPPER   = 3'd2,
    REG_LEFT_UPPER   = 3'd3,
    REG_SELECT_UPPER = 3'd4,
    REG_DEB_LIMIT    = 3'd5
  } reg_e;

  typedef struct packed {
    logic                 en;
    act_e                 action;
    logic                 sel;
    logic [NUM_FLAGS-1:0] mask;
  } btn_cmd_t;

endpackage

>>> rtl/akd_window.sv
module akd_window (
  input  logic [akd_pkg::SAMPLE_W-1:0]                          sample_i,
  input  logic [akd_pkg::NUM_BUTTONS-1:0][akd_pkg::SAMPLE_W-1:0] bound_i,
  output logic [akd_pkg::NUM_BUTTONS-1:0]                        hit_o
);

  always_comb begin
    hit_o[0] = sample_i < bound_i[0];
    for (int i = 1; i < akd_pkg::NUM_BUTTONS; i++) begin
      hit_o[i] = (sample_i > bound_i[i-1]) && (sample_i < bound_i[i]);
    end
  end

endmodule

>>> rtl/akd_button.sv
module akd_button (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  akd_pkg::btn_cmd_t             cmd_i,
  input  logic                          hit_i,
  input  logic [akd_pkg::COUNT_W-1:0]   limit_i,
  output logic [akd_pkg::NUM_FLAGS-1:0] flags_o,
  output logic [akd_pkg::NUM_FLAGS-1:0] flags_next_o
);

  logic [akd_pkg::COUNT_W-1:0]   cnt_q, cnt_d;
  logic [akd_pkg::NUM_FLAGS-1:0] flags_q, flags_d;

  always_comb begin
    cnt_d   = cnt_q;
    flags_d = flags_q;
    if (cmd_i.en) begin
      case (cmd_i.action)
        akd_pkg::ACT_TICK: begin
          if (!flags_q[akd_pkg::FLAG_LOCKED]) begin
            if (!hit_i) begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - akd_pkg::COUNT_W'(1);
              end else if (flags_q[akd_pkg::FLAG_PRESSED]) begin
                flags_d[akd_pkg::FLAG_REL_EV]    = 1'b1;
                flags_d[akd_pkg::FLAG_UNPRESSED] = 1'b1;
                flags_d[akd_pkg::FLAG_PRESSED]   = 1'b0;
              end
            end else begin
              if (cnt_q < limit_i) begin
                cnt_d = cnt_q + akd_pkg::COUNT_W'(1);
              end else if (flags_q[akd_pkg::FLAG_UNPRESSED]) begin
                flags_d[akd_pkg::FLAG_PRESS_EV]  = 1'b1;
                flags_d[akd_pkg::FLAG_PRESSED]   = 1'b1;
                flags_d[akd_pkg::FLAG_UNPRESSED] = 1'b0;
              end
            end
          end
        end
        akd_pkg::ACT_SET: begin
          if (cmd_i.sel) begin
            flags_d = flags_q | cmd_i.mask;
          end
        end
        akd_pkg::ACT_CLEAR: begin
          if (cmd_i.sel) begin
            flags_d = flags_q & ~cmd_i.mask;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      flags_q <= akd_pkg::FLAGS_RESET;
    end else begin
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

  assign flags_o      = flags_q;
  assign flags_next_o = flags_d;

endmodule

>>> rtl/adc_ladder_keypad_debouncer.sv
// path: a word accepted on the slave side passes through the input register, then the result register,
//   before it is shown on the master side
// throughput: one word per cycle while the master side accepts; the input register holds while the result waits
// reset: thresholds and debounce limit to their defaults, counters to zero,
//   every button unpressed with no events and no lock, both registers empty
module adc_ladder_keypad_debouncer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [akd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [akd_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // adc_sample [7:0], button_index [10:8], flag_mask [15:11]
  input  logic [akd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // action [1:0]
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pressed_mask [4:0], unpressed_mask [9:5], press_event_mask [14:10],
  // release_event_mask [19:15], locked_mask [24:20], zeros above
  output logic [akd_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int NB = akd_pkg::NUM_BUTTONS;
  localparam int NF = akd_pkg::NUM_FLAGS;

  // config registers
  logic [NB-1:0][akd_pkg::SAMPLE_W-1:0] bound_q;
  logic [akd_pkg::COUNT_W-1:0]          limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q[0] <= akd_pkg::RIGHT_UPPER_RST;
      bound_q[1] <= akd_pkg::UP_UPPER_RST;
      bound_q[2] <= akd_pkg::DOWN_UPPER_RST;
      bound_q[3] <= akd_pkg::LEFT_UPPER_RST;
      bound_q[4] <= akd_pkg::SELECT_UPPER_RST;
      limit_q    <= akd_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      case (akd_pkg::reg_e'(cfg_addr_i))
        akd_pkg::REG_RIGHT_UPPER:  bound_q[0] <= cfg_wdata_i;
        akd_pkg::REG_UP_UPPER:     bound_q[1] <= cfg_wdata_i;
        akd_pkg::REG_DOWN_UPPER:   bound_q[2] <= cfg_wdata_i;
        akd_pkg::REG_LEFT_UPPER:   bound_q[3] <= cfg_wdata_i;
        akd_pkg::REG_SELECT_UPPER: bound_q[4] <= cfg_wdata_i;
        akd_pkg::REG_DEB_LIMIT:    limit_q    <= cfg_wdata_i[akd_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  logic                              in_valid_q;
  akd_pkg::act_e                     act_q;
  logic [akd_pkg::SAMPLE_W-1:0]      sample_q;
  logic [akd_pkg::BTN_IDX_W-1:0]     idx_q;
  logic [NF-1:0]                     mask_q;
  logic                              out_valid_q;
  logic [akd_pkg::OUT_USED_W-1:0]    out_data_q, out_data_d;
  logic                              adv;
  logic                              in_take;

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      act_q    <= akd_pkg::act_e'(s_axis_tuser);
      sample_q <= s_axis_tdata[7:0];
      idx_q    <= s_axis_tdata[10:8];
      mask_q   <= s_axis_tdata[15:11];
    end
  end

  // button update
  logic [NB-1:0]         hit;
  logic [NB-1:0][NF-1:0] flags, flags_next;

  akd_window u_window (
    .sample_i (sample_q),
    .bound_i  (bound_q),
    .hit_o    (hit)
  );

  for (genvar b = 0; b < NB; b++) begin : g_btn
    akd_pkg::btn_cmd_t cmd;

    assign cmd.en     = adv;
    assign cmd.action = act_q;
    assign cmd.sel    = (idx_q == akd_pkg::BTN_IDX_W'(b));
    assign cmd.mask   = mask_q;

    akd_button u_button (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .hit_i        (hit[b]),
      .limit_i      (limit_q),
      .flags_o      (flags[b]),
      .flags_next_o (flags_next[b])
    );
  end

  always_comb begin
    for (int k = 0; k < NF; k++) begin
      for (int b = 0; b < NB; b++) begin
        out_data_d[k*NB + b] = flags_next[b][k];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(akd_pkg::OUT_DATA_W - akd_pkg::OUT_USED_W){1'b0}}, out_data_q};

  logic [NB-1:0] locked_vec;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      locked_vec[b] = flags[b][akd_pkg::FLAG_LOCKED];
    end
  end

  a_tick_keeps_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && act_q == akd_pkg::ACT_TICK |=> $stable(locked_vec))
    else $error("lock flags changed on a sample tick");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(flags))
    else $error("button flags changed without a word moving");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid && m_axis_tdata[akd_pkg::OUT_USED_W-1:0] == $past(out_data_d))
    else $error("result register missed an update");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [akd_pkg::CFG_ADDR_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [akd_pkg::CFG_ADDR_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_PRESSED   = 5'(1) << akd_pkg::FLAG_PRESSED;
  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_UNPRESSED = 5'(1) << akd_pkg::FLAG_UNPRESSED;
  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_PRESS_EV  = 5'(1) << akd_pkg::FLAG_PRESS_EV;
  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_REL_EV    = 5'(1) << akd_pkg::FLAG_REL_EV;
  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_LOCKED    = 5'(1) << akd_pkg::FLAG_LOCKED;
  localparam logic [akd_pkg::NUM_FLAGS-1:0] M_ALL       = 5'h1F;

  localparam int NUM_PHASES   = 8;
  localparam int PHASE_WORDS  = 240;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_LIMIT  = 2000;
  localparam int DIR_ROWS     = 21;

  // one bit per button in each field
  typedef struct packed {
    logic [akd_pkg::NUM_BUTTONS-1:0] locked;
    logic [akd_pkg::NUM_BUTTONS-1:0] rel_ev;
    logic [akd_pkg::NUM_BUTTONS-1:0] press_ev;
    logic [akd_pkg::NUM_BUTTONS-1:0] unpressed;
    logic [akd_pkg::NUM_BUTTONS-1:0] pressed;
  } flags_word_t;

  typedef struct packed {
    logic [1:0]                    act;
    logic [akd_pkg::SAMPLE_W-1:0]  smp;
    logic [akd_pkg::BTN_IDX_W-1:0] idx;
    logic [akd_pkg::NUM_FLAGS-1:0] msk;
    logic                          typed;
    flags_word_t                   want;
  } dir_row_t;

  localparam flags_word_t IDLE_FLAGS = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00};

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    {ACT_NONE,           8'd0,   3'd0, 5'd0,  1'b1, IDLE_FLAGS},
    {akd_pkg::ACT_SET,   8'hFF,  3'd7, M_ALL, 1'b1, IDLE_FLAGS},
    {akd_pkg::ACT_CLEAR, 8'h00,  3'd5, M_ALL, 1'b1, IDLE_FLAGS},
    {akd_pkg::ACT_SET,   8'd0,   3'd0, M_ALL, 1'b1, {5'h01, 5'h01, 5'h01, 5'h1F, 5'h01}},
    {akd_pkg::ACT_CLEAR, 8'd0,   3'd0, M_ALL, 1'b1, {5'h00, 5'h00, 5'h00, 5'h1E, 5'h00}},
    {akd_pkg::ACT_SET,   8'd0,   3'd0, M_UNPRESSED, 1'b1, IDLE_FLAGS},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd0,   3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd25,  3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_SET,   8'd0,   3'd1, M_LOCKED, 1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd40,  3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_CLEAR, 8'd0,   3'd1, M_LOCKED, 1'b0, 25'd0},
    {akd_pkg::ACT_SET,   8'd0,   3'd2, M_PRESSED, 1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd255, 3'd0, 5'd0,  1'b0, 25'd0},
    {akd_pkg::ACT_CLEAR, 8'd0,   3'd0, M_PRESS_EV | M_REL_EV, 1'b0, 25'd0},
    {akd_pkg::ACT_TICK,  8'd255, 3'd0, 5'd0,  1'b0, 25'd0},
    {ACT_NONE,           8'd255, 3'd7, M_ALL, 1'b0, 25'd0}
  };

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [akd_pkg::CFG_ADDR_W-1:0]     cfg_addr_i;
  logic [akd_pkg::CFG_DATA_W-1:0]     cfg_wdata_i;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [akd_pkg::IN_DATA_W-1:0]      s_axis_tdata;
  logic [1:0]                         s_axis_tuser;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [akd_pkg::OUT_DATA_W-1:0]     m_axis_tdata;

  // keypad shadow state
  logic [akd_pkg::SAMPLE_W-1:0]  bound [akd_pkg::NUM_BUTTONS];
  logic [akd_pkg::COUNT_W-1:0]   deb_limit;
  logic [akd_pkg::COUNT_W-1:0]   deb_cnt [akd_pkg::NUM_BUTTONS];
  logic [akd_pkg::NUM_FLAGS-1:0] btn_fl [akd_pkg::NUM_BUTTONS];

  flags_word_t result_q [$];
  logic        typed_pending;
  flags_word_t typed_word;

  logic quiet;
  logic hold_req;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   fails;
  int   words_in;
  int   words_out;
  int   ticks;
  int   press_edges;
  int   release_edges;
  int   settings;

  adc_ladder_keypad_debouncer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void keypad_reset();
    bound[0]  = akd_pkg::RIGHT_UPPER_RST;
    bound[1]  = akd_pkg::UP_UPPER_RST;
    bound[2]  = akd_pkg::DOWN_UPPER_RST;
    bound[3]  = akd_pkg::LEFT_UPPER_RST;
    bound[4]  = akd_pkg::SELECT_UPPER_RST;
    deb_limit = akd_pkg::LIMIT_RST;
    for (int b = 0; b < akd_pkg::NUM_BUTTONS; b++) begin
      deb_cnt[b] = '0;
      btn_fl[b]  = akd_pkg::FLAGS_RESET;
    end
  endfunction

  function automatic void shadow_write(logic [akd_pkg::CFG_ADDR_W-1:0] a,
                                       logic [akd_pkg::CFG_DATA_W-1:0] d);
    case (a)
      akd_pkg::REG_RIGHT_UPPER:  bound[0] = d;
      akd_pkg::REG_UP_UPPER:     bound[1] = d;
      akd_pkg::REG_DOWN_UPPER:   bound[2] = d;
      akd_pkg::REG_LEFT_UPPER:   bound[3] = d;
      akd_pkg::REG_SELECT_UPPER: bound[4] = d;
      akd_pkg::REG_DEB_LIMIT:    deb_limit = d[akd_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic in_window(int b, logic [akd_pkg::SAMPLE_W-1:0] v);
    if (b == 0) return v < bound[0];
    return v > bound[b-1] && v < bound[b];
  endfunction

  function automatic flags_word_t keypad_step(logic [1:0] act,
                                              logic [akd_pkg::SAMPLE_W-1:0] smp,
                                              logic [akd_pkg::BTN_IDX_W-1:0] idx,
                                              logic [akd_pkg::NUM_FLAGS-1:0] msk);
    logic [akd_pkg::NUM_FLAGS-1:0] f;
    flags_word_t w;
    case (act)
      akd_pkg::ACT_TICK: begin
        ticks++;
        for (int b = 0; b < akd_pkg::NUM_BUTTONS; b++) begin
          f = btn_fl[b];
          if (!f[akd_pkg::FLAG_LOCKED]) begin
            if (!in_window(b, smp)) begin
              if (deb_cnt[b] != 0) begin
                deb_cnt[b]--;
              end else if (f[akd_pkg::FLAG_PRESSED]) begin
                f[akd_pkg::FLAG_REL_EV]    = 1'b1;
                f[akd_pkg::FLAG_UNPRESSED] = 1'b1;
                f[akd_pkg::FLAG_PRESSED]   = 1'b0;
                release_edges++;
              end
            end else begin
              if (deb_cnt[b] < deb_limit) begin
                deb_cnt[b]++;
              end else if (f[akd_pkg::FLAG_UNPRESSED]) begin
                f[akd_pkg::FLAG_PRESS_EV]  = 1'b1;
                f[akd_pkg::FLAG_PRESSED]   = 1'b1;
                f[akd_pkg::FLAG_UNPRESSED] = 1'b0;
                press_edges++;
              end
            end
          end
          btn_fl[b] = f;
        end
      end
      akd_pkg::ACT_SET:   if (idx < akd_pkg::NUM_BUTTONS) btn_fl[idx] = btn_fl[idx] | msk;
      akd_pkg::ACT_CLEAR: if (idx < akd_pkg::NUM_BUTTONS) btn_fl[idx] = btn_fl[idx] & ~msk;
      default: ;
    endcase
    for (int b = 0; b < akd_pkg::NUM_BUTTONS; b++) begin
      w.pressed[b]   = btn_fl[b][akd_pkg::FLAG_PRESSED];
      w.unpressed[b] = btn_fl[b][akd_pkg::FLAG_UNPRESSED];
      w.press_ev[b]  = btn_fl[b][akd_pkg::FLAG_PRESS_EV];
      w.rel_ev[b]    = btn_fl[b][akd_pkg::FLAG_REL_EV];
      w.locked[b]    = btn_fl[b][akd_pkg::FLAG_LOCKED];
    end
    return w;
  endfunction

  function automatic logic [akd_pkg::SAMPLE_W-1:0] window_sample(int b);
    int lo;
    int hi;
    if (b >= akd_pkg::NUM_BUTTONS) return 8'($urandom);
    lo = (b == 0) ? 0 : int'(bound[b-1]) + 1;
    hi = int'(bound[b]) - 1;
    if (hi < lo) return 8'($urandom);
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic int idle_pick();
    case ($urandom_range(3))
      2: return 20;
      3: return 50;
      default: return 0;
    endcase
  endfunction

  // result checker and keypad prediction, both on the rising edge
  always @(posedge clk_i) begin
    flags_word_t want;
    flags_word_t got;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: %0h", m_axis_tdata);
          fails++;
        end else begin
          want = result_q.pop_front();
          got  = flags_word_t'(m_axis_tdata[akd_pkg::OUT_USED_W-1:0]);
          if (got.pressed !== want.pressed) begin
            $error("pressed_mask: expected %0h, got %0h", want.pressed, got.pressed);
            fails++;
          end
          if (got.unpressed !== want.unpressed) begin
            $error("unpressed_mask: expected %0h, got %0h", want.unpressed, got.unpressed);
            fails++;
          end
          if (got.press_ev !== want.press_ev) begin
            $error("press_event_mask: expected %0h, got %0h", want.press_ev, got.press_ev);
            fails++;
          end
          if (got.rel_ev !== want.rel_ev) begin
            $error("release_event_mask: expected %0h, got %0h", want.rel_ev, got.rel_ev);
            fails++;
          end
          if (got.locked !== want.locked) begin
            $error("locked_mask: expected %0h, got %0h", want.locked, got.locked);
            fails++;
          end
          if (m_axis_tdata[akd_pkg::OUT_DATA_W-1:akd_pkg::OUT_USED_W] !== '0) begin
            $error("tdata padding: expected 0, got %0h",
                   m_axis_tdata[akd_pkg::OUT_DATA_W-1:akd_pkg::OUT_USED_W]);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = keypad_step(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[10:8],
                           s_axis_tdata[15:11]);
        if (typed_pending) want = typed_word;
        result_q.push_back(want);
        words_in++;
      end
    end
  end

  // receiver side
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < sink_idle_pct) begin
        stall_left = $urandom_range(11, 1) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic [1:0] act, logic [akd_pkg::SAMPLE_W-1:0] smp,
                           logic [akd_pkg::BTN_IDX_W-1:0] idx,
                           logic [akd_pkg::NUM_FLAGS-1:0] msk,
                           logic typed, flags_word_t want);
    if (!quiet && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {msk, idx, smp};
    typed_pending <= typed;
    typed_word    <= want;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [akd_pkg::CFG_ADDR_W-1:0] a,
                           logic [akd_pkg::CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= a;
    cfg_wdata_i <= d;
    shadow_write(a, d);
    @(negedge clk_i);
  endtask

  task automatic program_regs(int p);
    logic [5*akd_pkg::SAMPLE_W-1:0] bnd;
    logic [akd_pkg::COUNT_W-1:0]    lim;
    int acc;
    case (p)
      0: begin bnd = {8'd230, 8'd180, 8'd115, 8'd65, 8'd25}; lim = 4'd5;  end
      1: begin bnd = {8'd230, 8'd180, 8'd115, 8'd65, 8'd25}; lim = 4'd15; end
      2: begin bnd = {8'd230, 8'd180, 8'd115, 8'd65, 8'd25}; lim = 4'd0;  end
      3: begin bnd = '0;                                     lim = 4'd3;  end
      4: begin bnd = '1;                                     lim = 4'd1;  end
      5: begin bnd = {8'd10, 8'd50, 8'd100, 8'd150, 8'd200}; lim = 4'd2;  end
      default: begin
        acc = $urandom_range(60);
        for (int b = 0; b < akd_pkg::NUM_BUTTONS; b++) begin
          bnd[b*akd_pkg::SAMPLE_W +: akd_pkg::SAMPLE_W] = 8'((acc > 255) ? 255 : acc);
          acc += $urandom_range(55, 2);
        end
        lim = 4'($urandom_range(15));
      end
    endcase
    cfg_write(akd_pkg::REG_RIGHT_UPPER,  bnd[7:0]);
    cfg_write(akd_pkg::REG_UP_UPPER,     bnd[15:8]);
    cfg_write(akd_pkg::REG_DOWN_UPPER,   bnd[23:16]);
    cfg_write(akd_pkg::REG_LEFT_UPPER,   bnd[31:24]);
    cfg_write(akd_pkg::REG_SELECT_UPPER, bnd[39:32]);
    cfg_write(akd_pkg::REG_DEB_LIMIT,    {4'd0, lim});
    cfg_write($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, 8'($urandom));
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(int n_words);
    int left;
    int run_len;
    int b;
    int r;
    logic [akd_pkg::NUM_FLAGS-1:0] msk;
    left = n_words;
    while (left > 0) begin
      if (!quiet && $urandom_range(11) == 0) begin
        src_idle_pct  = idle_pick();
        sink_idle_pct = idle_pick();
      end
      r = $urandom_range(99);
      if (r < 70) begin
        // hold one window for a while so the counters saturate
        b = $urandom_range(akd_pkg::NUM_BUTTONS);
        run_len = $urandom_range(20, 1);
        for (int k = 0; k < run_len && left > 0; k++) begin
          send_word(akd_pkg::ACT_TICK,
                    ($urandom_range(9) == 0) ? 8'($urandom) : window_sample(b),
                    3'($urandom), 5'($urandom), 1'b0, '0);
          left--;
        end
      end else if (r < 88) begin
        msk = 5'($urandom);
        if ($urandom_range(3) != 0) msk[akd_pkg::FLAG_LOCKED] = 1'b0;
        send_word($urandom_range(1) ? akd_pkg::ACT_SET : akd_pkg::ACT_CLEAR, 8'($urandom),
                  3'($urandom_range(7)), msk, 1'b0, '0);
        left--;
      end else if (r < 97) begin
        send_word(akd_pkg::ACT_CLEAR, 8'($urandom),
                  3'($urandom_range(akd_pkg::NUM_BUTTONS - 1)),
                  M_PRESS_EV | M_REL_EV, 1'b0, '0);
        left--;
      end else begin
        send_word(ACT_NONE, 8'($urandom), 3'($urandom), 5'($urandom), 1'b0, '0);
        left--;
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("adc_ladder_keypad_debouncer verification failed");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    typed_pending = 1'b0;
    typed_word    = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    src_idle_pct  = 20;
    sink_idle_pct = 20;
    fails         = 0;
    words_in      = 0;
    words_out     = 0;
    ticks         = 0;
    press_edges   = 0;
    release_edges = 0;
    settings      = 0;
    keypad_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++)
      send_word(DIR_TAB[i].act, DIR_TAB[i].smp, DIR_TAB[i].idx, DIR_TAB[i].msk,
                DIR_TAB[i].typed, DIR_TAB[i].want);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      program_regs(p);
      if (p == NUM_PHASES - 1) begin
        quiet = 1'b1;
      end else begin
        src_idle_pct  = idle_pick();
        sink_idle_pct = idle_pick();
      end
      // long receiver stall while words keep coming
      if (p == 1 || p == 4) hold_req = 1'b1;
      run_phase(PHASE_WORDS);
      drain();
    end

    if (result_q.size() != 0) begin
      $error("%0d expected results never arrived", result_q.size());
      fails++;
    end
    $display("run covered %0d words in, %0d results out, %0d of them sample ticks",
             words_in, words_out, ticks);
    $display("debounce gave %0d presses and %0d releases over %0d register settings",
             press_edges, release_edges, settings);
    if (fails == 0) begin
      $display("adc_ladder_keypad_debouncer verification clean");
    end else begin
      $display("adc_ladder_keypad_debouncer verification failed");
    end
    $finish;
  end

endmodule
